// ===== sv/hpc_pkg.sv =====
// Package for the heading controller: constants, CORDIC angle table, register codes.
package hpc_pkg;

  localparam int unsigned CordicStagesDef = 16;
  localparam int unsigned MaxStages       = 24;
  localparam int unsigned VecW            = 60;
  localparam int unsigned AngW            = 34;
  localparam int unsigned PrescaleSh      = 24;
  localparam int unsigned AddrW           = 4;

  localparam logic signed [AngW-1:0] HalfPiQ30 = 34'sd1686629713;
  localparam logic signed [16:0]     PiQ13     = 17'sd25736;
  localparam logic signed [24:0]     CmdMax    = 25'sd8388607;
  localparam logic signed [24:0]     CmdMin    = -25'sd8388608;

  localparam logic [31:0] AtanQ30 [MaxStages] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  typedef enum logic [1:0] {
    RegTargetX  = 2'd0,
    RegTargetY  = 2'd1,
    RegMinRad   = 2'd2,
    RegGain     = 2'd3
  } reg_idx_e;

endpackage

// ===== sv/heading_p_controller.sv =====
// Proportional heading controller: pipelined CORDIC yaw and bearing, error, gain.
//
// Usage: pulse start with a pose sample (position and orientation quaternion) on
// the input ports; the item is taken at any edge where start is high, since busy
// stays low and the pipeline takes one item every cycle. Each item yields one
// result on yaw_rate_cmd_o, current_yaw_o and inside_radius_o, shown for a single
// cycle with done_o high (the CORDIC stage count is limited to 24). Throughput is one
// item per cycle; each item passes through the three front stages (difference and
// products, sums and squares, prescale and quadrant fold), one register per CORDIC
// iteration for both angle units, and three back stages (rounding and wrap, gain
// multiply, round and clamp); the first front register loads at the accepting edge.
// Target, minimum radius and gain are set over the APB port (byte addresses
// 0, 4, 8, 12); pready is always high and reads return the register values.
// Reset clears the pipeline valid bits and loads the register defaults: target at
// the origin, radius 1.0 m, gain 1.0. The receiver takes every result as it is
// shown; there is no back pressure on the result side.
module heading_p_controller #(
  parameter int unsigned CORDIC_STAGES = hpc_pkg::CordicStagesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hpc_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [31:0]         pos_x_i,
  input  logic signed [31:0]         pos_y_i,
  input  logic signed [15:0]         quat_x_i,
  input  logic signed [15:0]         quat_y_i,
  input  logic signed [15:0]         quat_z_i,
  input  logic signed [15:0]         quat_w_i,
  output logic                       done_o,
  output logic signed [23:0]         yaw_rate_cmd_o,
  output logic signed [15:0]         current_yaw_o,
  output logic                       inside_radius_o
);

  localparam int unsigned NumStg = (CORDIC_STAGES > hpc_pkg::MaxStages) ?
                                   hpc_pkg::MaxStages : CORDIC_STAGES;
  localparam int unsigned W  = hpc_pkg::VecW;
  localparam int unsigned ZW = hpc_pkg::AngW;

  // configuration registers
  logic signed [31:0] tgt_x_q, tgt_y_q;
  logic [30:0]        min_rad_q;
  logic [15:0]        gain_q;
  logic               wr_en;
  hpc_pkg::reg_idx_e  wr_idx;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr_en  = psel && penable && pwrite;
  assign wr_idx = hpc_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_x_q   <= '0;
      tgt_y_q   <= '0;
      min_rad_q <= 31'd65536;
      gain_q    <= 16'd256;
    end else if (wr_en) begin
      unique case (wr_idx)
        hpc_pkg::RegTargetX: tgt_x_q   <= pwdata;
        hpc_pkg::RegTargetY: tgt_y_q   <= pwdata;
        hpc_pkg::RegMinRad:  min_rad_q <= pwdata[30:0];
        hpc_pkg::RegGain:    gain_q    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (wr_idx)
      hpc_pkg::RegTargetX: prdata = tgt_x_q;
      hpc_pkg::RegTargetY: prdata = tgt_y_q;
      hpc_pkg::RegMinRad:  prdata = {1'b0, min_rad_q};
      hpc_pkg::RegGain:    prdata = {16'd0, gain_q};
      default:             prdata = '0;
    endcase
  end

  // stage 1: differences and quaternion products
  logic               v1_q;
  logic signed [32:0] dx1_q, dy1_q;
  logic signed [31:0] pxy_q, pwz_q, pww_q, pxx_q, pyy_q, pzz_q;

  always_ff @(posedge clk_i) begin
    dx1_q <= 33'(tgt_x_q) - 33'(pos_x_i);
    dy1_q <= 33'(tgt_y_q) - 33'(pos_y_i);
    pxy_q <= quat_x_i * quat_y_i;
    pwz_q <= quat_w_i * quat_z_i;
    pww_q <= quat_w_i * quat_w_i;
    pxx_q <= quat_x_i * quat_x_i;
    pyy_q <= quat_y_i * quat_y_i;
    pzz_q <= quat_z_i * quat_z_i;
  end

  // stage 2: yaw vector sums, squared distance terms
  logic               v2_q;
  logic signed [33:0] sy2_q, cy2_q;
  logic signed [32:0] dx2_q, dy2_q;
  logic [63:0]        d2x_q, d2y_q;
  logic [61:0]        r2_q;
  logic signed [32:0] ax_s, ay_s;

  assign ax_s = dx1_q[32] ? -dx1_q : dx1_q;
  assign ay_s = dy1_q[32] ? -dy1_q : dy1_q;

  always_ff @(posedge clk_i) begin
    sy2_q <= (34'(pxy_q) + 34'(pwz_q)) <<< 1;
    cy2_q <= 34'(pww_q) + 34'(pxx_q) - 34'(pyy_q) - 34'(pzz_q);
    dx2_q <= dx1_q;
    dy2_q <= dy1_q;
    d2x_q <= ax_s[31:0] * ax_s[31:0];
    d2y_q <= ay_s[31:0] * ay_s[31:0];
    r2_q  <= min_rad_q * min_rad_q;
  end

  // stage 3: prescale, quadrant fold, distance test
  logic signed [W-1:0]  yx_q [NumStg+1];
  logic signed [W-1:0]  yy_q [NumStg+1];
  logic signed [ZW-1:0] yzz_q [NumStg+1];
  logic signed [W-1:0]  bx_q [NumStg+1];
  logic signed [W-1:0]  by_q [NumStg+1];
  logic signed [ZW-1:0] bzz_q [NumStg+1];
  logic                 ynil_q [NumStg+1];
  logic                 bnil_q [NumStg+1];
  logic                 ins_q [NumStg+1];
  logic                 vc_q [NumStg+1];

  logic signed [W-1:0] yxp, yyp, bxp, byp;
  logic [64:0]         d2_sum;
  logic [63:0]         d2_sat;

  assign yxp    = W'(cy2_q) <<< hpc_pkg::PrescaleSh;
  assign yyp    = W'(sy2_q) <<< hpc_pkg::PrescaleSh;
  assign bxp    = W'(dx2_q) <<< hpc_pkg::PrescaleSh;
  assign byp    = W'(dy2_q) <<< hpc_pkg::PrescaleSh;
  assign d2_sum = {1'b0, d2x_q} + {1'b0, d2y_q};
  assign d2_sat = d2_sum[64] ? '1 : d2_sum[63:0];

  always_ff @(posedge clk_i) begin
    ynil_q[0] <= (cy2_q == '0) && (sy2_q == '0);
    bnil_q[0] <= (dx2_q == '0) && (dy2_q == '0);
    ins_q[0]  <= d2_sat < {2'b00, r2_q};
    if (yxp < 0) begin
      if (yyp >= 0) begin
        yx_q[0] <= yyp;  yy_q[0] <= -yxp; yzz_q[0] <= hpc_pkg::HalfPiQ30;
      end else begin
        yx_q[0] <= -yyp; yy_q[0] <= yxp;  yzz_q[0] <= -hpc_pkg::HalfPiQ30;
      end
    end else begin
      yx_q[0] <= yxp; yy_q[0] <= yyp; yzz_q[0] <= '0;
    end
    if (bxp < 0) begin
      if (byp >= 0) begin
        bx_q[0] <= byp;  by_q[0] <= -bxp; bzz_q[0] <= hpc_pkg::HalfPiQ30;
      end else begin
        bx_q[0] <= -byp; by_q[0] <= bxp;  bzz_q[0] <= -hpc_pkg::HalfPiQ30;
      end
    end else begin
      bx_q[0] <= bxp; by_q[0] <= byp; bzz_q[0] <= '0;
    end
  end

  // CORDIC vectoring iterations, one register per iteration
  for (genvar k = 0; k < NumStg; k++) begin : g_stg
    localparam logic signed [ZW-1:0] Ang = ZW'($signed({1'b0, hpc_pkg::AtanQ30[k]}));
    always_ff @(posedge clk_i) begin
      ynil_q[k+1] <= ynil_q[k];
      bnil_q[k+1] <= bnil_q[k];
      ins_q[k+1]  <= ins_q[k];
      if (yy_q[k] >= 0) begin
        yx_q[k+1]  <= yx_q[k] + (yy_q[k] >>> k);
        yy_q[k+1]  <= yy_q[k] - (yx_q[k] >>> k);
        yzz_q[k+1] <= yzz_q[k] + Ang;
      end else begin
        yx_q[k+1]  <= yx_q[k] - (yy_q[k] >>> k);
        yy_q[k+1]  <= yy_q[k] + (yx_q[k] >>> k);
        yzz_q[k+1] <= yzz_q[k] - Ang;
      end
      if (by_q[k] >= 0) begin
        bx_q[k+1]  <= bx_q[k] + (by_q[k] >>> k);
        by_q[k+1]  <= by_q[k] - (bx_q[k] >>> k);
        bzz_q[k+1] <= bzz_q[k] + Ang;
      end else begin
        bx_q[k+1]  <= bx_q[k] - (by_q[k] >>> k);
        by_q[k+1]  <= by_q[k] + (bx_q[k] >>> k);
        bzz_q[k+1] <= bzz_q[k] - Ang;
      end
    end
  end

  // back stage 1: round angles, wrap error
  logic signed [ZW-1:0] yz_r, bz_r;
  logic signed [15:0]   yaw_s, brg_s;
  logic signed [16:0]   err_raw, err_w1, err_w2;
  logic signed [15:0]   yaw_e1_q;
  logic signed [16:0]   err_e1_q;
  logic                 ins_e1_q;

  assign yz_r    = yzz_q[NumStg] + ZW'(65536);
  assign bz_r    = bzz_q[NumStg] + ZW'(65536);
  assign yaw_s   = ynil_q[NumStg] ? '0 : yz_r[32:17];
  assign brg_s   = bnil_q[NumStg] ? '0 : bz_r[32:17];
  assign err_raw = 17'(brg_s) - 17'(yaw_s);
  assign err_w1  = (err_raw > hpc_pkg::PiQ13) ? err_raw - (hpc_pkg::PiQ13 <<< 1) : err_raw;
  assign err_w2  = (err_w1 < -hpc_pkg::PiQ13) ? err_w1 + (hpc_pkg::PiQ13 <<< 1) : err_w1;

  always_ff @(posedge clk_i) begin
    yaw_e1_q <= yaw_s;
    err_e1_q <= ins_q[NumStg] ? '0 : err_w2;
    ins_e1_q <= ins_q[NumStg];
  end

  // back stage 2: gain multiply
  logic signed [33:0] prod_e2_q;
  logic signed [15:0] yaw_e2_q;
  logic               ins_e2_q;

  always_ff @(posedge clk_i) begin
    prod_e2_q <= $signed({1'b0, gain_q}) * err_e1_q;
    yaw_e2_q  <= yaw_e1_q;
    ins_e2_q  <= ins_e1_q;
  end

  // back stage 3: round and clamp
  logic signed [33:0] prod_r;
  logic signed [25:0] cmd_s;

  assign prod_r = prod_e2_q + 34'sd128;
  assign cmd_s  = 26'(prod_r >>> 8);

  always_ff @(posedge clk_i) begin
    if (cmd_s > 26'(hpc_pkg::CmdMax)) begin
      yaw_rate_cmd_o <= hpc_pkg::CmdMax[23:0];
    end else if (cmd_s < 26'(hpc_pkg::CmdMin)) begin
      yaw_rate_cmd_o <= hpc_pkg::CmdMin[23:0];
    end else begin
      yaw_rate_cmd_o <= cmd_s[23:0];
    end
    current_yaw_o   <= yaw_e2_q;
    inside_radius_o <= ins_e2_q;
  end

  // valid chain
  logic v_e1_q, v_e2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v_e1_q <= 1'b0;
      v_e2_q <= 1'b0;
      done_o <= 1'b0;
    end else begin
      v1_q   <= start;
      v2_q   <= v1_q;
      v_e1_q <= vc_q[NumStg];
      v_e2_q <= v_e1_q;
      done_o <= v_e2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q[0] <= 1'b0;
    end else begin
      vc_q[0] <= v2_q;
    end
  end

  for (genvar k = 0; k < NumStg; k++) begin : g_vld
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vc_q[k+1] <= 1'b0;
      end else begin
        vc_q[k+1] <= vc_q[k];
      end
    end
  end

endmodule
